/* rtl/dlam_pkg.sv */
// Shared constants, types and helpers for the DRAM line address mapper.
// No dependencies; every other file uses this package.
package dlam_pkg;

  localparam int GANG_SIZE_DEF      = 4;
  localparam int LINE_ADDR_BITS_DEF = 28;

  localparam int DIV_W      = 11;  // widest divisor: lines_per_row
  localparam int ROW_W      = 28;
  localparam int BANK_W     = 6;
  localparam int CHAN_W     = 3;
  localparam int LIMIT_W    = 29;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 29;
  localparam int STAGES     = 4;   // divisions applied to each address
  localparam int STAGE_W    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_POLICY,
    REG_CHANNEL_COUNT,
    REG_BANKS_PER_CHANNEL,
    REG_LINES_PER_ROW,
    REG_LINE_LIMIT
  } cfg_reg_t;

  typedef enum logic [1:0] {
    POL_ROW,
    POL_PAIR,
    POL_GANG,
    POL_LINE
  } policy_t;

  // Indices picked up as the item travels down the chain
  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [BANK_W-1:0] bank;
    logic              oor;
  } side_t;

  // Clamp channel count into 1..8
  function automatic logic [3:0] nch_eff(input logic [3:0] n);
    logic [3:0] r;
    r = n;
    if (n == 4'd0) r = 4'd1;
    else if (n > 4'd8) r = 4'd8;
    return r;
  endfunction

  // Clamp bank count into 1..64
  function automatic logic [6:0] nbk_eff(input logic [6:0] n);
    logic [6:0] r;
    r = n;
    if (n == 7'd0) r = 7'd1;
    else if (n > 7'd64) r = 7'd64;
    return r;
  endfunction

endpackage

/* rtl/dlam_if.sv */
// Valid/ready channel interfaces for the address mapper: input, result, config.
// Depends on dlam_pkg.
interface dlam_in_if #(parameter int AW = dlam_pkg::LINE_ADDR_BITS_DEF);
  logic          valid;
  logic          ready;
  logic [AW-1:0] line_addr;
  modport source (output valid, output line_addr, input ready);
  modport sink   (input valid, input line_addr, output ready);
endinterface

interface dlam_out_if;
  logic                         valid;
  logic                         ready;
  logic [dlam_pkg::ROW_W-1:0]   row_index;
  logic [dlam_pkg::BANK_W-1:0]  bank_index;
  logic [dlam_pkg::CHAN_W-1:0]  channel_index;
  logic                         out_of_range;
  modport source (output valid, output row_index, output bank_index,
                  output channel_index, output out_of_range, input ready);
  modport sink   (input valid, input row_index, input bank_index,
                  input channel_index, input out_of_range, output ready);
endinterface

interface dlam_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dlam_pkg::CFG_IDX_W-1:0]  index;
  logic [dlam_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/dlam_cell.sv */
// One restoring-division step: shifts one dividend bit in, emits one quotient bit.
// Depends on dlam_pkg.
module dlam_cell #(
  parameter int AW = dlam_pkg::LINE_ADDR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic [dlam_pkg::DIV_W-1:0] in_rem,
  input  logic [AW-1:0]              in_word,
  input  dlam_pkg::side_t            in_side,
  input  logic [dlam_pkg::DIV_W-1:0] divisor,
  output logic                       valid_r,
  output logic [dlam_pkg::DIV_W-1:0] rem_r,
  output logic [AW-1:0]              word_r,
  output dlam_pkg::side_t            side_r
);
  import dlam_pkg::*;

  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             ge;
  logic [DIV_W-1:0] rem_nxt;
  logic [AW-1:0]    word_nxt;

  // Trial subtract of the divisor from the partial remainder
  always_comb begin
    trial    = {in_rem, in_word[AW-1]};
    diff     = trial - {1'b0, divisor};
    ge       = (trial >= {1'b0, divisor});
    rem_nxt  = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    word_nxt = {in_word[AW-2:0], ge};
  end

  // Advance the item when the chain moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r  <= rem_nxt;
      word_r <= word_nxt;
      side_r <= in_side;
    end
  end

endmodule

/* rtl/dram_line_address_mapper.sv */
// Top level of the DRAM line address mapper: config registers, chain of
// division cells, result register. Depends on dlam_pkg, dlam_if, dlam_cell.
//
//  channel   | direction | payload
//  in_ch     | sink      | line_addr
//  out_ch    | source    | row_index, bank_index, channel_index, out_of_range
//  cfg_ch    | sink      | index, data (always ready)
//
// One address is taken every cycle while the chain moves; a result is offered
// once its address has passed the four long divisions, done one quotient bit per
// cell along the chain, the last cell loading the output register.
// Reset clears all valid flags and loads the config reset values.
// The whole chain holds while a result waits untaken in the output register.
module dram_line_address_mapper #(
  parameter int GANG_SIZE      = dlam_pkg::GANG_SIZE_DEF,
  parameter int LINE_ADDR_BITS = dlam_pkg::LINE_ADDR_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  dlam_in_if.sink    in_ch,
  dlam_out_if.source out_ch,
  dlam_cfg_if.sink   cfg_ch
);
  import dlam_pkg::*;

  localparam int AW    = LINE_ADDR_BITS;
  localparam int NCELL = STAGES * AW;
  localparam int CMP_W = (AW > LIMIT_W) ? AW : LIMIT_W;

  // Reciprocal of the gang size, exact for every DIV_W-bit row size
  localparam int                GS_SHIFT = DIV_W + 7;
  localparam longint            GS_MUL_L = ((longint'(1) << GS_SHIFT) +
                                            longint'(GANG_SIZE) - 1) / longint'(GANG_SIZE);
  localparam logic [GS_SHIFT:0] GS_MUL   = GS_MUL_L[GS_SHIFT:0];

  logic [1:0]         map_policy_r;
  logic [3:0]         channel_count_r;
  logic [6:0]         banks_per_channel_r;
  logic [DIV_W-1:0]   lines_per_row_r;
  logic [LIMIT_W-1:0] line_limit_r;

  policy_t            pol;
  logic [3:0]         nch;
  logic [6:0]         nbk;
  logic [DIV_W+GS_SHIFT:0] gang_prod;
  logic [DIV_W-1:0]   stage_div [STAGES];
  logic [STAGE_W-1:0] chan_stage;
  logic [STAGE_W-1:0] bank_stage;
  logic               adv;

  logic               c_valid [NCELL];
  logic [DIV_W-1:0]   c_rem   [NCELL];
  logic [AW-1:0]      c_word  [NCELL];
  side_t              c_side  [NCELL];
  logic               i_valid [NCELL];
  logic [DIV_W-1:0]   i_rem   [NCELL];
  logic [AW-1:0]      i_word  [NCELL];
  side_t              i_side  [NCELL];

  logic [AW-1:0]      fin_q;
  side_t              fin_side;

  logic               out_valid_r;
  logic [ROW_W-1:0]   row_r;
  logic [BANK_W-1:0]  bank_r;
  logic [CHAN_W-1:0]  chan_r;
  logic               oor_r;

  // Config register writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_policy_r        <= 2'd0;
      channel_count_r     <= 4'd1;
      banks_per_channel_r <= 7'd32;
      lines_per_row_r     <= 11'd128;
      line_limit_r        <= 29'd268435456;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_MAP_POLICY:        map_policy_r        <= cfg_ch.data[1:0];
        REG_CHANNEL_COUNT:     channel_count_r     <= cfg_ch.data[3:0];
        REG_BANKS_PER_CHANNEL: banks_per_channel_r <= cfg_ch.data[6:0];
        REG_LINES_PER_ROW:     lines_per_row_r     <= cfg_ch.data[DIV_W-1:0];
        REG_LINE_LIMIT:        line_limit_r        <= cfg_ch.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Divisor for each stage, and the stages whose remainders give channel and bank
  always_comb begin
    pol = policy_t'(map_policy_r);
    nch = nch_eff(channel_count_r);
    nbk = nbk_eff(banks_per_channel_r);
    gang_prod = {{(GS_SHIFT+1){1'b0}}, lines_per_row_r} * {{DIV_W{1'b0}}, GS_MUL};
    chan_stage = STAGE_W'(1);
    bank_stage = STAGE_W'(2);
    case (pol)
      POL_ROW: begin
        stage_div[0] = lines_per_row_r;
        stage_div[1] = DIV_W'(nch);
        stage_div[2] = DIV_W'(nbk);
        stage_div[3] = DIV_W'(1);
      end
      POL_PAIR: begin
        stage_div[0] = DIV_W'(2);
        stage_div[1] = DIV_W'(nch);
        stage_div[2] = {1'b0, lines_per_row_r[DIV_W-1:1]};
        stage_div[3] = DIV_W'(nbk);
        bank_stage   = STAGE_W'(3);
      end
      POL_GANG: begin
        stage_div[0] = DIV_W'(GANG_SIZE);
        stage_div[1] = DIV_W'(nch);
        stage_div[2] = DIV_W'(nbk);
        stage_div[3] = gang_prod[DIV_W+GS_SHIFT-1:GS_SHIFT];
      end
      default: begin
        stage_div[0] = DIV_W'(nch);
        stage_div[1] = DIV_W'(2);
        stage_div[2] = DIV_W'(nbk);
        stage_div[3] = {1'b0, lines_per_row_r[DIV_W-1:1]};
        chan_stage   = STAGE_W'(0);
      end
    endcase
  end

  // Chain moves unless a result waits untaken
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Feed each cell: entry, inside a stage, or at a stage seam
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    localparam int S = k / AW;
    if (k == 0) begin : g_entry
      always_comb begin
        i_valid[k]     = in_ch.valid;
        i_rem[k]       = '0;
        i_word[k]      = in_ch.line_addr;
        i_side[k].chan = '0;
        i_side[k].bank = '0;
        i_side[k].oor  = (CMP_W'(in_ch.line_addr) >= CMP_W'(line_limit_r));
      end
    end else if (k % AW == 0) begin : g_seam
      always_comb begin
        i_valid[k] = c_valid[k-1];
        i_rem[k]   = '0;
        i_word[k]  = (stage_div[S-1] == '0) ? '0 : c_word[k-1];
        i_side[k]  = c_side[k-1];
        if (chan_stage == STAGE_W'(S-1)) i_side[k].chan = c_rem[k-1][CHAN_W-1:0];
        if (bank_stage == STAGE_W'(S-1)) i_side[k].bank = c_rem[k-1][BANK_W-1:0];
      end
    end else begin : g_mid
      always_comb begin
        i_valid[k] = c_valid[k-1];
        i_rem[k]   = c_rem[k-1];
        i_word[k]  = c_word[k-1];
        i_side[k]  = c_side[k-1];
      end
    end

    dlam_cell #(.AW(AW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_valid (i_valid[k]),
      .in_rem   (i_rem[k]),
      .in_word  (i_word[k]),
      .in_side  (i_side[k]),
      .divisor  (stage_div[S]),
      .valid_r  (c_valid[k]),
      .rem_r    (c_rem[k]),
      .word_r   (c_word[k]),
      .side_r   (c_side[k])
    );
  end

  // Last seam: final quotient is the row
  always_comb begin
    fin_q    = (stage_div[STAGES-1] == '0) ? '0 : c_word[NCELL-1];
    fin_side = c_side[NCELL-1];
    if (bank_stage == STAGE_W'(STAGES-1)) fin_side.bank = c_rem[NCELL-1][BANK_W-1:0];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= c_valid[NCELL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      row_r  <= ROW_W'(fin_q);
      bank_r <= fin_side.bank;
      chan_r <= fin_side.chan;
      oor_r  <= fin_side.oor;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.row_index     = row_r;
  assign out_ch.bank_index    = bank_r;
  assign out_ch.channel_index = chan_r;
  assign out_ch.out_of_range  = oor_r;

  // Checks
  a_chan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({1'b0, chan_r} < nch))
    else $error("channel index not below channel count");

  a_bank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({1'b0, bank_r} < nbk))
    else $error("bank index not below bank count");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (c_valid[NCELL-1] && adv) |=> out_valid_r)
    else $error("item lost leaving the chain");

  a_zero_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && pol == POL_ROW && lines_per_row_r == '0)
      |-> (row_r == '0 && bank_r == '0 && chan_r == '0))
    else $error("zero row size must give all-zero indices");

endmodule
